[rtl/core/maf_pkg.sv]
// ----------------------------------------------------------------------------
// Moving average filter package
// Shared widths, register indexes, controller states and the divider status
// bundle used by the boxcar moving average filter core.
// ----------------------------------------------------------------------------
package maf_pkg;

  localparam int DATA_W         = 16;
  localparam int WS_W           = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int WINDOW_MAX_DEF = 128;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE  = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REFILL,
    ST_READ,
    ST_SUB,
    ST_ADD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

[rtl/core/maf_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module maf_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/maf_div.sv]
// ----------------------------------------------------------------------------
// Bit-serial signed divider
// Restoring division of a signed sum by an unsigned window length, one
// quotient bit per cycle, with the quotient truncated toward zero.
// ----------------------------------------------------------------------------
module maf_div #(
  parameter int SUM_W = 24,
  parameter int DIV_W = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [SUM_W-1:0]           dividend,
  input  logic [DIV_W-1:0]                  divisor,
  output logic signed [maf_pkg::DATA_W-1:0] quotient,
  output maf_pkg::div_rsp_t                 rsp
);

  import maf_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic             neg_r, neg_nxt;
  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;

  logic [SUM_W-1:0] dividend_u;
  logic [SUM_W-1:0] mag;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             fits;

  assign dividend_u = dividend;
  assign mag   = dividend[SUM_W-1] ? (~dividend_u + SUM_W'(1)) : dividend_u;
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = CNT_W'(SUM_W);
      neg_nxt = dividend[SUM_W-1];
      quo_nxt = mag;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      // The dividend shifts out at the top while quotient bits enter below.
      quo_nxt  = {quo_r[SUM_W-2:0], fits};
      rem_nxt  = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  // The average always fits the output width, so only the low bits matter.
  assign quotient = neg_r ? $signed(~quo_r[DATA_W-1:0] + DATA_W'(1))
                          : $signed(quo_r[DATA_W-1:0]);

  assign rsp.busy = (cnt_r != '0);
  assign rsp.done = done_r;

endmodule

[rtl/core/moving_average_filter_core.sv]
// ----------------------------------------------------------------------------
// Boxcar moving average filter core
// Keeps a circular window of recent samples and a running sum, and returns
// the window average truncated toward zero for every input sample.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_sample) takes one signed sample
//   per beat; the result channel (out_valid, out_stall, out_average) returns
//   one signed average per sample, in order. The configuration port writes
//   window_size (index 0) or fill_value (index 1); any such write refills the
//   window with fill_value, clears the write position and reloads the sum.
//   Writes to other indexes are ignored.
//   One sample is processed at a time. An accepted sample passes through the
//   read, subtract, add, divider start, divider wait and output states before
//   the next acceptance, the wait set by the bit-serial divider that produces
//   one quotient bit per cycle; the result is loaded in the output state.
//   A configuration write holds in_stall high for one cycle while the sum
//   is reloaded. After reset the window is 1 and the fill value is 0.
//   The result sits in an output register; while the receiver stalls, the
//   next sample is still accepted and processed, and only the transfer of
//   its result waits.
// ----------------------------------------------------------------------------
module moving_average_filter_core #(
  parameter int WINDOW_MAX = maf_pkg::WINDOW_MAX_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [maf_pkg::DATA_W-1:0]     in_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [maf_pkg::DATA_W-1:0]     out_average,
  input  logic                                  cfg_we,
  input  logic [maf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [maf_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  import maf_pkg::*;

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = DATA_W + CNT_W;
  localparam int CMP_W = (CNT_W > WS_W) ? CNT_W : WS_W;

  state_t state_r, state_nxt;

  logic [WS_W-1:0]          window_size_r, window_size_nxt;
  logic signed [DATA_W-1:0] fill_value_r, fill_value_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     wrapped_r, wrapped_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [DATA_W-1:0] sample_r, sample_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_average_r, out_average_nxt;

  logic                      cfg_hit;
  logic [CNT_W-1:0]          n;
  logic [CNT_W-1:0]          idx_inc;
  logic signed [SUM_W:0]     fill_prod;
  logic [DATA_W-1:0]         ram_rdata;
  logic signed [DATA_W-1:0]  old_sample;
  logic                      ram_re;
  logic                      ram_we;
  logic                      div_start;
  logic                      out_load;
  logic signed [DATA_W-1:0]  div_quot;
  div_rsp_t                  div_rsp;

  assign cfg_hit = cfg_we &&
                   (cfg_index == REG_WINDOW_SIZE || cfg_index == REG_FILL_VALUE);

  // Effective window length, clamped to 1..WINDOW_MAX.
  always_comb begin
    if (window_size_r == '0) begin
      n = CNT_W'(1);
    end else if (CMP_W'(window_size_r) > CMP_W'(WINDOW_MAX)) begin
      n = CNT_W'(WINDOW_MAX);
    end else begin
      n = CNT_W'(window_size_r);
    end
  end

  assign idx_inc   = CNT_W'(idx_r) + CNT_W'(1);
  assign fill_prod = fill_value_r * $signed({1'b0, n});

  // Entries are written in order from zero after a refill, so the entry at
  // the write position holds a sample only once the position has wrapped.
  assign old_sample = wrapped_r ? $signed(ram_rdata) : fill_value_r;

  maf_ram #(
    .WIDTH  (DATA_W),
    .DEPTH  (WINDOW_MAX),
    .ADDR_W (IDX_W)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (sample_r),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  maf_div #(
    .SUM_W (SUM_W),
    .DIV_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (n),
    .quotient (div_quot),
    .rsp      (div_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_REFILL:   state_nxt = ST_IDLE;
      ST_READ:     state_nxt = ST_SUB;
      ST_SUB:      state_nxt = ST_ADD;
      ST_ADD:      state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
    if (cfg_hit) begin
      state_nxt = ST_REFILL;
    end
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    ram_re    = (state_r == ST_IDLE) && in_valid;
    ram_we    = (state_r == ST_SUB);
    div_start = (state_r == ST_DIV_GO);
    out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    window_size_nxt = window_size_r;
    fill_value_nxt  = fill_value_r;
    idx_nxt         = idx_r;
    wrapped_nxt     = wrapped_r;
    sum_nxt         = sum_r;
    sample_nxt      = sample_r;

    if (cfg_we && cfg_index == REG_WINDOW_SIZE) begin
      window_size_nxt = cfg_wdata[WS_W-1:0];
    end
    if (cfg_we && cfg_index == REG_FILL_VALUE) begin
      fill_value_nxt = $signed(cfg_wdata[DATA_W-1:0]);
    end

    if (ram_re) begin
      sample_nxt = in_sample;
    end

    case (state_r)
      ST_REFILL: begin
        idx_nxt     = '0;
        wrapped_nxt = 1'b0;
        sum_nxt     = fill_prod[SUM_W-1:0];
      end
      ST_SUB: begin
        sum_nxt = sum_r - SUM_W'(old_sample);
        if (idx_inc == n) begin
          idx_nxt     = '0;
          wrapped_nxt = 1'b1;
        end else begin
          idx_nxt = idx_inc[IDX_W-1:0];
        end
      end
      ST_ADD: begin
        sum_nxt = sum_r + SUM_W'(sample_r);
      end
      default: begin
      end
    endcase

    out_valid_nxt   = out_load ? 1'b1 : (out_valid_r && out_stall);
    out_average_nxt = out_load ? div_quot : out_average_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      window_size_r <= WS_W'(1);
      fill_value_r  <= '0;
      idx_r         <= '0;
      wrapped_r     <= 1'b0;
      sum_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      window_size_r <= window_size_nxt;
      fill_value_r  <= fill_value_nxt;
      idx_r         <= idx_nxt;
      wrapped_r     <= wrapped_nxt;
      sum_r         <= sum_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r      <= sample_nxt;
    out_average_r <= out_average_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

  a_idx_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> CNT_W'(idx_r) < n)
    else $error("write position outside the active window");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !cfg_hit |=> state_r == ST_READ)
    else $error("accepted beat did not start a window read");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result appeared outside the output load state");

  a_refill_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_REFILL && !cfg_hit |=> idx_r == '0 && !wrapped_r)
    else $error("refill did not clear the write position");

endmodule

[dv/tb_moving_average_filter_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the boxcar moving average filter core
// Sends signed samples with random gaps and random receiver stalls. A local
// model tracks the window contents, the write position and the running sum,
// and each average is checked in order against it. The run steps through
// many window sizes and fill values. These include the saturating sizes,
// writes to unused register indexes and rewrites of an unchanged value.
// ----------------------------------------------------------------------------
module tb_moving_average_filter_core;
  import maf_pkg::*;

  localparam int WINDOW_MAX   = WINDOW_MAX_DEF;
  localparam int IDLE_PCT     = 22;
  localparam int REG_GAP      = WINDOW_MAX + 40;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int STEADY_PHASE = 4;
  localparam int MAX_REPORTS  = 100;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  localparam logic signed [DATA_W-1:0] SAMPLE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] SAMPLE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  logic                         clk         = 1'b0;
  logic                         rst_n       = 1'b0;
  logic                         in_valid    = 1'b0;
  logic                         in_stall;
  logic signed [DATA_W-1:0]     in_sample   = '0;
  logic                         out_valid;
  logic                         out_stall   = 1'b0;
  logic signed [DATA_W-1:0]     out_average;
  logic                         cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index   = '0;
  logic [CFG_DATA_W-1:0]        cfg_wdata   = '0;

  // Model state of the filter.
  logic [WS_W-1:0]              reg_wsize;
  logic [DATA_W-1:0]            reg_fill;
  logic signed [DATA_W-1:0]     win_mem [WINDOW_MAX];
  int                           win_pos;
  int                           win_sum;

  logic signed [DATA_W-1:0]     pending_samples [$];
  logic signed [DATA_W-1:0]     avg_expected [$];

  logic                         steady      = 1'b0;
  int                           err_count   = 0;
  int                           checked     = 0;
  int                           cycle_count = 0;

  moving_average_filter_core #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_average (out_average),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int active_len();
    int n;
    n = int'(reg_wsize);
    if (n < 1) n = 1;
    if (n > WINDOW_MAX) n = WINDOW_MAX;
    return n;
  endfunction

  function automatic void reload_window();
    for (int i = 0; i < WINDOW_MAX; i++) win_mem[i] = reg_fill;
    win_pos = 0;
    win_sum = int'(signed'(reg_fill)) * active_len();
  endfunction

  // Writes to indexes outside the register list leave the window untouched.
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_WINDOW_SIZE: reg_wsize = val[WS_W-1:0];
      REG_FILL_VALUE:  reg_fill  = val[DATA_W-1:0];
      default:         return;
    endcase
    reload_window();
  endfunction

  function automatic logic signed [DATA_W-1:0] window_average(
    input logic signed [DATA_W-1:0] s);
    int n;
    int pos;
    n   = active_len();
    pos = win_pos;
    if (pos >= n) pos = 0;
    win_sum = win_sum - int'(win_mem[pos]) + int'(s);
    win_mem[pos] = s;
    pos++;
    if (pos >= n) pos = 0;
    win_pos = pos;
    return DATA_W'(win_sum / n);
  endfunction

  function automatic void push_int(input int v);
    pending_samples.push_back(DATA_W'(v));
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2, 3:    return DATA_W'($urandom_range(32) - 16);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_fill();
    case ($urandom_range(4))
      0:       return CFG_DATA_W'(SAMPLE_MIN);
      1:       return CFG_DATA_W'(SAMPLE_MAX);
      2:       return '0;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid || avg_expected.size() != 0)
      @(posedge clk);
  endtask

  // Registers change only with nothing in flight, and the pause also covers
  // the refill that the previous write started.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    repeat (REG_GAP) @(posedge clk);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_we    <= 1'b1;
    apply_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin : drive_samples
    logic take;
    take = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (take) avg_expected.push_back(window_average(in_sample));
      if (!in_valid || take) begin
        if (pending_samples.size() != 0 &&
            (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid  <= 1'b1;
          in_sample <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_averages
    logic signed [DATA_W-1:0] want;
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    if (rst_n && out_valid && !out_stall) begin
      if (avg_expected.size() == 0) begin
        report_mismatch($sformatf("average %0d with no sample pending", out_average));
      end else begin
        want = avg_expected.pop_front();
        if (out_average !== want)
          report_mismatch($sformatf("beat %0d: average %0d, expected %0d",
                                    checked, out_average, want));
      end
      checked++;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** moving_average_filter_core: FAILED **");
      $finish;
    end
  end

  initial begin : run_test
    int total;
    int len;
    int phase;
    int ws;
    logic [CFG_DATA_W-1:0] wdata;
    logic [CFG_DATA_W-1:0] fill;

    reg_wsize = WS_W'(1);
    reg_fill  = '0;
    reload_window();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Window of one and zero fill straight out of reset.
    push_int(-32768);
    push_int(32767);
    push_int(0);
    push_int(-1);
    push_int(1);

    // Negative sums must truncate toward zero; upper data bits are ignored.
    write_reg(REG_WINDOW_SIZE, 16'hA503);
    push_int(-1);
    push_int(-1);
    push_int(-2);
    push_int(7);

    // A size of zero behaves as a window of one.
    write_reg(REG_WINDOW_SIZE, 16'h0000);
    push_int(100);
    push_int(-100);

    // A size above the maximum saturates, with the window full of minimums.
    write_reg(REG_FILL_VALUE, 16'h8000);
    write_reg(REG_WINDOW_SIZE, 16'h00FF);
    push_int(32767);
    push_int(32767);
    push_int(-32768);

    write_reg(REG_WINDOW_SIZE, 16'(WINDOW_MAX));
    write_reg(REG_FILL_VALUE, 16'h7FFF);
    push_int(-32768);
    push_int(32767);
    push_int(0);

    // Unused indexes must not refill, so the window carries on.
    write_reg(REG_UNUSED_2, 16'hFFFF);
    write_reg(REG_UNUSED_3, 16'h0000);
    push_int(5);
    push_int(-5);

    // Rewriting the same value still refills.
    write_reg(REG_FILL_VALUE, 16'h7FFF);
    push_int(1);

    write_reg(REG_WINDOW_SIZE, 16'h0002);
    write_reg(REG_FILL_VALUE, 16'hFFFD);
    push_int(4);
    push_int(-7);
    push_int(1);

    total = 0;
    phase = 0;
    while (total < RANDOM_ITEMS) begin
      steady = (phase == STEADY_PHASE);
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: ws = $urandom_range(12, 1);
        6:                ws = $urandom_range(WINDOW_MAX - 1, 13);
        7:                ws = WINDOW_MAX;
        8:                ws = $urandom_range(255, WINDOW_MAX + 1);
        default:          ws = 0;
      endcase
      wdata = CFG_DATA_W'($urandom);
      wdata[WS_W-1:0] = WS_W'(ws);
      fill = rand_fill();
      if ($urandom_range(1) == 1) begin
        write_reg(REG_WINDOW_SIZE, wdata);
        write_reg(REG_FILL_VALUE, fill);
      end else begin
        write_reg(REG_FILL_VALUE, fill);
        write_reg(REG_WINDOW_SIZE, wdata);
      end
      if ($urandom_range(3) == 0)
        write_reg(($urandom_range(1) == 1) ? REG_UNUSED_3 : REG_UNUSED_2,
                  CFG_DATA_W'($urandom));
      len = $urandom_range(140, 60);
      repeat (len) pending_samples.push_back(rand_sample());
      total += len;
      phase++;
      wait_idle();
    end
    steady = 1'b0;

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("** moving_average_filter_core: PASSED **");
    end else begin
      $display("** moving_average_filter_core: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/maf_pkg.sv
rtl/core/maf_ram.sv
rtl/core/maf_div.sv
rtl/core/moving_average_filter_core.sv
dv/tb_moving_average_filter_core.sv
